>>> rtl/ebc_pkg.sv
// Shared types, codes and helpers for the eight-bit execute block.
package ebc_pkg;

   localparam int QueueDepth = 2;

   localparam logic [1:0] ACCESS_NONE  = 2'd0;
   localparam logic [1:0] ACCESS_READ  = 2'd1;
   localparam logic [1:0] ACCESS_WRITE = 2'd2;

   localparam logic [2:0] TARGET_A   = 3'd0;
   localparam logic [2:0] TARGET_B   = 3'd1;
   localparam logic [2:0] TARGET_C   = 3'd2;
   localparam logic [2:0] TARGET_D   = 3'd3;
   localparam logic [2:0] TARGET_E   = 3'd4;
   localparam logic [2:0] TARGET_INC = 3'd5;
   localparam logic [2:0] TARGET_DEC = 3'd6;
   localparam logic [2:0] TARGET_NONE = 3'd7;

   localparam logic [3:0] FLAG_Z = 4'b1000;
   localparam logic [3:0] FLAG_N = 4'b0100;
   localparam logic [3:0] FLAG_H = 4'b0010;
   localparam logic [3:0] FLAG_C = 4'b0001;

   typedef struct packed {
      logic       operation;
      logic [7:0] opcode;
      logic [7:0] imm_low;
      logic [7:0] imm_high;
      logic [7:0] read_data;
      logic [1:0] length;
   } item_type;

   typedef struct packed {
      logic [1:0]  access_kind;
      logic [15:0] access_address;
      logic [7:0]  write_data;
      logic [15:0] program_counter;
      logic [7:0]  accumulator_out;
      logic [3:0]  flags_out;
      logic        waiting_read;
      logic        protocol_error;
      logic        last;
   } result_type;

   function automatic logic [1:0] op_length(input logic [7:0] op);
      logic [1:0] len;
      len = 2'd1;
      if (op == 8'h01 || op == 8'h11 || op == 8'h21 || op == 8'h31 || op == 8'h08)
         len = 2'd3;
      else if (op < 8'h40 && (op[2:0] == 3'd6 || op == 8'h18 || op == 8'h20 ||
                              op == 8'h28 || op == 8'h30 || op == 8'h38))
         len = 2'd2;
      return len;
   endfunction

endpackage

>>> rtl/ebc_front.sv
// Front end: accept words, work out instruction length and queue them.
module ebc_front
   import ebc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   item_type          mem_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]     cnt_ff, cnt_in;
   logic              push, pop;
   item_type          tagged_item;

   always_comb begin
      tagged_item        = in_item;
      tagged_item.length = op_length(in_item.opcode);
      in_ready  = (cnt_ff != (PtrW+1)'(QueueDepth));
      out_valid = (cnt_ff != '0);
      out_item  = mem_ff[rd_ff];
      push = in_valid && in_ready;
      pop  = out_valid && out_ready;
      wr_in = (push) ? ((wr_ff == PtrW'(QueueDepth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in = (pop) ? ((rd_ff == PtrW'(QueueDepth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= tagged_item;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end
endmodule

>>> rtl/ebc_back.sv
// Back end: register file, execute and result output register.
module ebc_back
   import ebc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);
   logic [7:0]  acc_ff, acc_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in;
   logic [7:0]  h_ff, h_in, l_ff, l_in;
   logic [3:0]  f_ff, f_in;
   logic [15:0] sp_ff, sp_in, pc_ff, pc_in, paddr_ff, paddr_in;
   logic        pend_ff, pend_in;
   logic [2:0]  ptgt_ff, ptgt_in;
   logic        ovalid_ff, ovalid_in, second_ff, second_in;
   result_type  res_ff, res_in;
   logic [15:0] sec_addr_ff, sec_addr_in;
   logic [7:0]  sec_data_ff, sec_data_in;

   logic        take;
   logic [15:0] hl, bc, de, n16, v16, addop;
   logic [16:0] sum17;
   logic [7:0]  src, rv, dv, dst;
   logic [1:0]  kind;
   logic [15:0] addr;
   logic [7:0]  wdata;
   logic        err, two, jmp;
   logic [7:0]  adj, da;
   logic        dc;
   logic [2:0]  row, col;

   function automatic logic [7:0] pick(input logic [2:0] code, input logic [7:0] a,
      input logic [7:0] b, input logic [7:0] c, input logic [7:0] d,
      input logic [7:0] e, input logic [7:0] h, input logic [7:0] l);
      logic [7:0] r;
      case (code)
         3'd0: r = b;
         3'd1: r = c;
         3'd2: r = d;
         3'd3: r = e;
         3'd4: r = h;
         3'd5: r = l;
         default: r = a;
      endcase
      return r;
   endfunction

   always_comb begin
      in_ready   = (!ovalid_ff || out_ready) && !second_ff;
      out_valid  = ovalid_ff;
      out_result = res_ff;
      take = in_valid && in_ready;
      acc_in = acc_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in = h_ff; l_in = l_ff; f_in = f_ff; sp_in = sp_ff; pc_in = pc_ff;
      pend_in = pend_ff; ptgt_in = ptgt_ff; paddr_in = paddr_ff;
      sec_addr_in = sec_addr_ff; sec_data_in = sec_data_ff;
      kind = ACCESS_NONE; addr = '0; wdata = '0; err = 1'b0; two = 1'b0;
      hl = {h_ff, l_ff}; bc = {b_ff, c_ff}; de = {d_ff, e_ff};
      n16 = {in_item.imm_high, in_item.imm_low};
      row = in_item.opcode[5:3]; col = in_item.opcode[2:0];
      src = pick(col, acc_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff);
      dst = pick(row, acc_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff);
      case (in_item.opcode[5:4])
         2'd0: addop = bc;
         2'd1: addop = de;
         2'd2: addop = hl;
         default: addop = sp_ff;
      endcase
      sum17 = {1'b0, hl} + {1'b0, addop};
      v16 = '0; rv = '0; dv = '0;
      jmp = 1'b0; adj = '0; da = '0; dc = 1'b0;

      if (take) begin
         if (in_item.operation != pend_ff) begin
            err = 1'b1;
         end else if (in_item.operation) begin
            pend_in = 1'b0;
            rv = in_item.read_data + 8'd1;
            dv = in_item.read_data - 8'd1;
            case (ptgt_ff)
               TARGET_A: acc_in = in_item.read_data;
               TARGET_B: b_in = in_item.read_data;
               TARGET_C: c_in = in_item.read_data;
               TARGET_D: d_in = in_item.read_data;
               TARGET_E: e_in = in_item.read_data;
               TARGET_INC: begin
                  f_in = (f_ff & FLAG_C) | ((rv == 8'd0) ? FLAG_Z : 4'd0) |
                         ((in_item.read_data[3:0] == 4'hF) ? FLAG_H : 4'd0);
                  kind = ACCESS_WRITE; addr = paddr_ff; wdata = rv;
               end
               TARGET_DEC: begin
                  f_in = (f_ff & FLAG_C) | FLAG_N | ((dv == 8'd0) ? FLAG_Z : 4'd0) |
                         ((in_item.read_data[3:0] == 4'h0) ? FLAG_H : 4'd0);
                  kind = ACCESS_WRITE; addr = paddr_ff; wdata = dv;
               end
               default: ;
            endcase
         end else begin
            pc_in = pc_ff + 16'(in_item.length);
            if (in_item.opcode >= 8'h40 && in_item.opcode < 8'h60) begin
               if (col == 3'd6) begin
                  pend_in = 1'b1; ptgt_in = 3'(row + 3'd1); paddr_in = hl;
                  kind = ACCESS_READ; addr = hl;
               end else begin
                  case (row)
                     3'd0: b_in = src;
                     3'd1: c_in = src;
                     3'd2: d_in = src;
                     default: e_in = src;
                  endcase
               end
            end else if (in_item.opcode < 8'h40) begin
               if (col == 3'd4 || col == 3'd5) begin
                  if (row == 3'd6) begin
                     pend_in = 1'b1; ptgt_in = (col == 3'd4) ? TARGET_INC : TARGET_DEC;
                     paddr_in = hl; kind = ACCESS_READ; addr = hl;
                  end else begin
                     rv = (col == 3'd4) ? dst + 8'd1 : dst - 8'd1;
                     f_in = (f_ff & FLAG_C) | ((col == 3'd5) ? FLAG_N : 4'd0) |
                            ((rv == 8'd0) ? FLAG_Z : 4'd0) |
                            (((col == 3'd4) ? (dst[3:0] == 4'hF) : (dst[3:0] == 4'h0))
                               ? FLAG_H : 4'd0);
                     case (row)
                        3'd0: b_in = rv;
                        3'd1: c_in = rv;
                        3'd2: d_in = rv;
                        3'd3: e_in = rv;
                        3'd4: h_in = rv;
                        3'd5: l_in = rv;
                        default: acc_in = rv;
                     endcase
                  end
               end else if (col == 3'd6) begin
                  case (row)
                     3'd0: b_in = in_item.imm_low;
                     3'd1: c_in = in_item.imm_low;
                     3'd2: d_in = in_item.imm_low;
                     3'd3: e_in = in_item.imm_low;
                     3'd4: h_in = in_item.imm_low;
                     3'd5: l_in = in_item.imm_low;
                     3'd6: begin kind = ACCESS_WRITE; addr = hl; wdata = in_item.imm_low; end
                     default: acc_in = in_item.imm_low;
                  endcase
               end else begin
                  case (in_item.opcode)
                     8'h01: begin b_in = in_item.imm_high; c_in = in_item.imm_low; end
                     8'h11: begin d_in = in_item.imm_high; e_in = in_item.imm_low; end
                     8'h21: begin h_in = in_item.imm_high; l_in = in_item.imm_low; end
                     8'h31: sp_in = n16;
                     8'h02: begin kind = ACCESS_WRITE; addr = bc; wdata = acc_ff; end
                     8'h12: begin kind = ACCESS_WRITE; addr = de; wdata = acc_ff; end
                     8'h22, 8'h32: begin
                        kind = ACCESS_WRITE; addr = hl; wdata = acc_ff;
                        v16 = in_item.opcode[4] ? hl - 16'd1 : hl + 16'd1;
                        h_in = v16[15:8]; l_in = v16[7:0];
                     end
                     8'h0A, 8'h1A, 8'h2A, 8'h3A: begin
                        addr = (in_item.opcode[5:4] == 2'd0) ? bc :
                               (in_item.opcode[5:4] == 2'd1) ? de : hl;
                        kind = ACCESS_READ; pend_in = 1'b1; ptgt_in = TARGET_A;
                        paddr_in = addr;
                        if (in_item.opcode[5]) begin
                           v16 = in_item.opcode[4] ? hl - 16'd1 : hl + 16'd1;
                           h_in = v16[15:8]; l_in = v16[7:0];
                        end
                     end
                     8'h03, 8'h13, 8'h23, 8'h33, 8'h0B, 8'h1B, 8'h2B, 8'h3B: begin
                        v16 = in_item.opcode[3] ? addop - 16'd1 : addop + 16'd1;
                        case (in_item.opcode[5:4])
                           2'd0: begin b_in = v16[15:8]; c_in = v16[7:0]; end
                           2'd1: begin d_in = v16[15:8]; e_in = v16[7:0]; end
                           2'd2: begin h_in = v16[15:8]; l_in = v16[7:0]; end
                           default: sp_in = v16;
                        endcase
                     end
                     8'h09, 8'h19, 8'h29, 8'h39: begin
                        f_in = (f_ff & FLAG_Z) |
                               (({1'b0, hl[11:0]} + {1'b0, addop[11:0]} > 13'hFFF)
                                  ? FLAG_H : 4'd0) | (sum17[16] ? FLAG_C : 4'd0);
                        h_in = sum17[15:8]; l_in = sum17[7:0];
                     end
                     8'h07: begin acc_in = {acc_ff[6:0], acc_ff[7]}; f_in = {3'd0, acc_ff[7]}; end
                     8'h0F: begin acc_in = {acc_ff[0], acc_ff[7:1]}; f_in = {3'd0, acc_ff[0]}; end
                     8'h17: begin acc_in = {acc_ff[6:0], f_ff[0]}; f_in = {3'd0, acc_ff[7]}; end
                     8'h1F: begin acc_in = {f_ff[0], acc_ff[7:1]}; f_in = {3'd0, acc_ff[0]}; end
                     8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
                        case (in_item.opcode)
                           8'h20: jmp = !f_ff[3];
                           8'h28: jmp = f_ff[3];
                           8'h30: jmp = !f_ff[0];
                           8'h38: jmp = f_ff[0];
                           default: jmp = 1'b1;
                        endcase
                        if (jmp)
                           pc_in = pc_ff + 16'(in_item.length) +
                                   {{8{in_item.imm_low[7]}}, in_item.imm_low};
                     end
                     8'h27: begin
                        dc = f_ff[0];
                        if (f_ff[2]) begin
                           adj = {1'b0, f_ff[0], f_ff[0], 2'b00, f_ff[1], f_ff[1], 1'b0};
                           da = acc_ff - adj;
                        end else begin
                           if (f_ff[1] || acc_ff[3:0] > 4'h9) adj = adj | 8'h06;
                           if (f_ff[0] || acc_ff > 8'h99) begin adj = adj | 8'h60; dc = 1'b1; end
                           da = acc_ff + adj;
                        end
                        acc_in = da;
                        f_in = ((da == 8'd0) ? FLAG_Z : 4'd0) | (f_ff & FLAG_N) |
                               (dc ? FLAG_C : 4'd0);
                     end
                     8'h2F: begin acc_in = ~acc_ff; f_in = f_ff | FLAG_N | FLAG_H; end
                     8'h37: f_in = (f_ff & FLAG_Z) | FLAG_C;
                     8'h3F: f_in = (f_ff & FLAG_Z) | {3'd0, ~f_ff[0]};
                     8'h08: begin
                        two = 1'b1; kind = ACCESS_WRITE; addr = n16; wdata = sp_ff[7:0];
                        sec_addr_in = n16 + 16'd1; sec_data_in = sp_ff[15:8];
                     end
                     default: ;
                  endcase
               end
            end
         end
      end

      ovalid_in = ovalid_ff; second_in = second_ff; res_in = res_ff;
      if (out_ready && ovalid_ff) ovalid_in = 1'b0;
      if (take) begin
         ovalid_in = 1'b1; second_in = two;
         res_in.access_kind = kind; res_in.access_address = addr;
         res_in.write_data = wdata; res_in.program_counter = pc_in;
         res_in.accumulator_out = acc_in; res_in.flags_out = f_in;
         res_in.waiting_read = pend_in; res_in.protocol_error = err;
         res_in.last = !two;
      end else if (second_ff && out_ready) begin
         ovalid_in = 1'b1; second_in = 1'b0;
         res_in.access_address = sec_addr_ff; res_in.write_data = sec_data_ff;
         res_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in; sec_addr_ff <= sec_addr_in; sec_data_ff <= sec_data_in;
      if (reset) begin
         acc_ff <= 8'h01; f_ff <= FLAG_Z; b_ff <= 8'h00; c_ff <= 8'h13;
         d_ff <= 8'h00; e_ff <= 8'hD8; h_ff <= 8'h01; l_ff <= 8'h4D;
         sp_ff <= 16'hFFFE; pc_ff <= 16'h0100;
         pend_ff <= 1'b0; ptgt_ff <= TARGET_A; paddr_ff <= '0;
         ovalid_ff <= 1'b0; second_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in; f_ff <= f_in; b_ff <= b_in; c_ff <= c_in;
         d_ff <= d_in; e_ff <= e_in; h_ff <= h_in; l_ff <= l_in;
         sp_ff <= sp_in; pc_ff <= pc_in;
         pend_ff <= pend_in; ptgt_ff <= ptgt_in; paddr_ff <= paddr_in;
         ovalid_ff <= ovalid_in; second_ff <= second_in;
      end
   end
endmodule

>>> rtl/eight_bit_cpu_execute_subset.sv
// Top level of the eight-bit execute block.
// Usage:
//   req_ carries one word per instruction or memory read reply; rsp_ returns
//   one word per item, two for the store of SP to an absolute address.
//   A word is moved when tvalid and tready are both high.
//   rsp_tvalid rises once the req_ word has passed the queue register and
//   then execute into the output register, from which the result is taken.
//   Throughput: one item per cycle while rsp_tready is high; the SP store
//   holds the back end until its second word has been issued.
//   Reset loads the power-on register values and empties the queue.
//   When rsp_tready is low the output register holds, the back end stops,
//   and the two-entry queue fills before req_tready falls.
module eight_bit_cpu_execute_subset
   import ebc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // opcode, imm_low, imm_high, read_data
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // access_kind, access_address, write_data,
                                   // program_counter, accumulator_out, flags_out,
                                   // waiting_read, protocol_error
   output logic        rsp_tlast
);
   item_type   in_item, q_item;
   logic       q_valid, q_ready;
   result_type res;

   always_comb begin
      in_item.operation = req_tuser;
      in_item.opcode    = req_tdata[7:0];
      in_item.imm_low   = req_tdata[15:8];
      in_item.imm_high  = req_tdata[23:16];
      in_item.read_data = req_tdata[31:24];
      in_item.length    = 2'd1;
      rsp_tdata = {res.protocol_error, res.waiting_read, res.flags_out,
                   res.accumulator_out, res.program_counter, res.write_data,
                   res.access_address, res.access_kind};
      rsp_tlast = res.last;
   end

   ebc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

   ebc_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res));

   a_err_no_access: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.protocol_error |-> res.access_kind == ACCESS_NONE)
      else $error("error word carries an access");
   a_read_waits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.access_kind == ACCESS_READ |-> res.waiting_read)
      else $error("read request without pending reply");
   a_first_not_last_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !res.last |-> res.access_kind == ACCESS_WRITE)
      else $error("non-final word is not a write");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
endmodule
